// File: sv/pph_pkg.sv
// Shared types and constants of the pixel projection histogram.
package pph_pkg;

  localparam int CFG_W  = 11;
  localparam int IDX_W  = 2;
  localparam int PIX_W  = 8;
  localparam int POS_W  = 10;
  localparam int LINE_W = 11;
  localparam int QUAD_W = 21;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_SPLIT_COLUMN = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPLIT_ROW    = 2'd3;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [CFG_W-1:0] RST_SPLIT_COLUMN = 11'd320;
  localparam logic [CFG_W-1:0] RST_SPLIT_ROW    = 11'd240;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_READ  = 1'b1;
  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_COL   = 1'b1;

  localparam logic [PIX_W-1:0]  SET_MASK = 8'hF0;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [QUAD_W-1:0] QUAD_MAX = '1;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_value;
    logic [POS_W-1:0] column_select;
  } pph_in_t;

  typedef struct packed {
    logic              result_kind;
    logic [POS_W-1:0]  position;
    logic [LINE_W-1:0] line_count;
    logic [QUAD_W-1:0] upper_left_count;
    logic [QUAD_W-1:0] upper_right_count;
    logic [QUAD_W-1:0] lower_left_count;
    logic [QUAD_W-1:0] lower_right_count;
    logic [QUAD_W-1:0] frame_total;
    logic              frame_done;
  } pph_out_t;

endpackage

// File: sv/pixel_projection_histogram.sv
// Pixel projection histogram: column store, row counts and quadrant totals.
//
// Input beats carry either a pixel (mode 0, raster order) or a column
// readout request (mode 1). A pixel counts as set when any of its upper
// four bits is one. Each pixel that closes a row gives one result beat with
// the row's set count and the quadrant totals so far; a readout gives one
// result beat with the stored count of the selected column.
// Throughput: one input beat per clock while in_ready is high. Column
// counts live in a single synchronous RAM, read when the beat is taken and
// written back in the next cycle; a write-to-read bypass covers
// back-to-back hits on one column. Results pass the stage 1 registers into
// a four-entry output FIFO; when the receiver stalls, in_ready drops once
// the queue plus the beat in flight would fill it, so no result is dropped.
// Write configuration through cfg_we only while idle; this is not enforced.
// Reset clears positions, row and quadrant counts and the queue, and loads
// the default geometry (640 x 480, split at 320 / 240). The column RAM is
// not cleared: read a column only after row 0 of a frame has written it.
module pixel_projection_histogram
  import pph_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pph_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pph_out_t         out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WW  = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
  localparam int HW  = (YW + 1 > CFG_W) ? YW + 1 : CFG_W;
  localparam int YE  = (YW > POS_W) ? YW : POS_W;
  localparam int FD  = 4;
  localparam int FPW = $clog2(FD);
  localparam int FCW = $clog2(FD + 1);
  localparam int SUMW = QUAD_W + 2;

  // configuration
  logic [CFG_W-1:0] frame_width_r, frame_height_r, split_column_r, split_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      split_column_r <= RST_SPLIT_COLUMN;
      split_row_r    <= RST_SPLIT_ROW;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_SPLIT_COLUMN: split_column_r <= cfg_data;
        REG_SPLIT_ROW:    split_row_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: position tracking, row and quadrant counts
  logic [XW-1:0]     col_pos_r, col_pos_nxt;
  logic [YW-1:0]     row_pos_r, row_pos_nxt;
  logic [LINE_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [QUAD_W-1:0] quad_r   [0:3];
  logic [QUAD_W-1:0] quad_nxt [0:3];

  logic          in_fire;
  logic [WW-1:0] w_ext, w_eff, x_ext, col_ext;
  logic [HW-1:0] h_ext, h_eff, y_ext;
  logic          pix_set, row_end, last_row, right_side, lower_side, col_in_range;
  logic [1:0]    quad_sel;
  logic [XW-1:0] rd_addr;
  logic [YE-1:0] y_pos_ext;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    w_ext = WW'(frame_width_r);
    if (w_ext == '0) w_eff = WW'(1);
    else if (w_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = w_ext;
    h_ext = HW'(frame_height_r);
    if (h_ext == '0) h_eff = HW'(1);
    else if (h_ext > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = h_ext;
  end

  assign pix_set      = |(in_data.pixel_value & SET_MASK);
  assign x_ext        = WW'(col_pos_r);
  assign y_ext        = HW'(row_pos_r);
  assign row_end      = (x_ext + WW'(1)) >= w_eff;
  assign last_row     = (y_ext + HW'(1)) >= h_eff;
  assign right_side   = x_ext >= WW'(split_column_r);
  assign lower_side   = y_ext >= HW'(split_row_r);
  assign quad_sel     = {lower_side, right_side};
  assign col_ext      = WW'(in_data.column_select);
  assign col_in_range = col_ext < WW'(MAX_WIDTH);
  assign rd_addr      = (in_data.mode == MODE_READ) ? col_ext[XW-1:0] : col_pos_r;
  assign y_pos_ext    = YE'(row_pos_r);

  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    row_cnt_nxt = row_cnt_r;
    for (int k = 0; k < 4; k++) quad_nxt[k] = quad_r[k];
    if (in_fire && in_data.mode == MODE_PIXEL) begin
      // first pixel of a frame restarts the quadrant totals
      if (col_pos_r == '0 && row_pos_r == '0) begin
        for (int k = 0; k < 4; k++) quad_nxt[k] = '0;
      end
      if (col_pos_r == '0) row_cnt_nxt = '0;
      if (pix_set) begin
        if (quad_nxt[quad_sel] != QUAD_MAX)
          quad_nxt[quad_sel] = quad_nxt[quad_sel] + QUAD_W'(1);
        if (row_cnt_nxt != LINE_MAX) row_cnt_nxt = row_cnt_nxt + LINE_W'(1);
      end
      if (row_end) begin
        col_pos_nxt = '0;
        row_pos_nxt = last_row ? '0 : row_pos_r + YW'(1);
      end else begin
        col_pos_nxt = col_pos_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      row_cnt_r <= '0;
      for (int k = 0; k < 4; k++) quad_r[k] <= '0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      row_cnt_r <= row_cnt_nxt;
      for (int k = 0; k < 4; k++) quad_r[k] <= quad_nxt[k];
    end
  end

  // stage 1 registers: RAM op and result snapshot
  logic              s1_valid_r, s1_res_r;
  logic              s1_pix_r, s1_first_r, s1_set_r, s1_inrng_r;
  logic [XW-1:0]     s1_addr_r;
  logic              s1_kind_r, s1_done_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [LINE_W-1:0] s1_line_r;
  logic [QUAD_W-1:0] s1_quad_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_res_r   <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      s1_res_r   <= in_fire && (in_data.mode == MODE_READ || row_end);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= (in_data.mode == MODE_PIXEL);
      s1_first_r <= (row_pos_r == '0);
      s1_set_r   <= pix_set;
      s1_inrng_r <= (in_data.mode == MODE_PIXEL) || col_in_range;
      s1_addr_r  <= rd_addr;
      s1_kind_r  <= (in_data.mode == MODE_READ) ? KIND_COL : KIND_ROW;
      s1_pos_r   <= (in_data.mode == MODE_READ) ? in_data.column_select
                                                : y_pos_ext[POS_W-1:0];
      s1_line_r  <= row_cnt_nxt;
      s1_done_r  <= (in_data.mode == MODE_PIXEL) && last_row;
      for (int k = 0; k < 4; k++) s1_quad_r[k] <= quad_nxt[k];
    end
  end

  // column count RAM, read-modify-write with bypass of last write
  logic [LINE_W-1:0] col_mem [0:MAX_WIDTH-1];
  logic [LINE_W-1:0] rd_data_r, cur_cnt, cnt_new, wr_data_r;
  logic [XW-1:0]     wr_addr_r;
  logic              wr_vld_r, mem_we;

  always_ff @(posedge clk) begin
    if (in_fire) rd_data_r <= col_mem[rd_addr];
  end

  assign cur_cnt = (wr_vld_r && wr_addr_r == s1_addr_r) ? wr_data_r : rd_data_r;
  assign mem_we  = s1_valid_r && s1_pix_r;

  always_comb begin
    if (s1_first_r) cnt_new = LINE_W'(s1_set_r);
    else if (s1_set_r && cur_cnt != LINE_MAX) cnt_new = cur_cnt + LINE_W'(1);
    else cnt_new = cur_cnt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) col_mem[s1_addr_r] <= cnt_new;
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= s1_addr_r;
    wr_data_r <= cnt_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wr_vld_r <= 1'b0;
    else wr_vld_r <= mem_we;
  end

  // result assembly
  pph_out_t        res;
  logic [SUMW-1:0] total_sum;

  always_comb begin
    total_sum = SUMW'(s1_quad_r[0]) + SUMW'(s1_quad_r[1])
              + SUMW'(s1_quad_r[2]) + SUMW'(s1_quad_r[3]);
    res.result_kind       = s1_kind_r;
    res.position          = s1_pos_r;
    res.line_count        = s1_pix_r ? s1_line_r : (s1_inrng_r ? cur_cnt : '0);
    res.upper_left_count  = s1_quad_r[0];
    res.upper_right_count = s1_quad_r[1];
    res.lower_left_count  = s1_quad_r[2];
    res.lower_right_count = s1_quad_r[3];
    res.frame_total       = (total_sum > SUMW'(QUAD_MAX)) ? QUAD_MAX
                                                          : total_sum[QUAD_W-1:0];
    res.frame_done        = s1_done_r;
  end

  // output FIFO
  pph_out_t       fifo_q [0:FD-1];
  logic [FPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0] cnt_r;
  logic           push, pop;

  assign push      = s1_valid_r && s1_res_r;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = fifo_q[rd_ptr_r];
  assign in_ready  = ((FCW+1)'(cnt_r) + (FCW+1)'(push)) < (FCW+1)'(FD);

  always_ff @(posedge clk) begin
    if (push) fifo_q[wr_ptr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FPW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + FPW'(1);
      if (push && !pop) cnt_r <= cnt_r + FCW'(1);
      else if (pop && !push) cnt_r <= cnt_r - FCW'(1);
    end
  end

endmodule
